>>> design/kmp_pkg.sv
// kmp_pkg: payload structs, controller/datapath command and status
// structs, and default sizes for the KMP string matcher. No dependencies.
`default_nettype none

package kmp_pkg;

    localparam int KMP_MAX_PATTERN = 256;
    localparam int KMP_POS_BITS    = 32;
    localparam int KMP_START_W     = 32;

    localparam logic KMP_MODE_PATTERN = 1'b0;
    localparam logic KMP_MODE_TEXT    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_in;
        logic       first;
    } kmp_in_t;

    typedef struct packed {
        logic                   match;
        logic [KMP_START_W-1:0] match_start;
        logic                   overflow;
    } kmp_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture input beat, apply restart
        logic set_ovf;       // pattern byte dropped
        logic pat_first;     // first pattern byte: store it, failure entry 0
        logic pat_start;     // store byte, chain walk starts at build length
        logic txt_empty;     // no pattern: only advance position
        logic txt_start;     // chain walk starts at matched count
        logic step;          // one failure-chain step
        logic pat_post;      // write failure entry, grow pattern
        logic txt_post;      // update match state and position, build result
        logic fail_sel_len;  // failure read at pattern length - 1
        logic mc_fix;        // matched count from failure entry after a match
        logic out_load;      // move result into output register
    } kmp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic full;
        logic len_zero;
        logic step_more;
        logic is_match;
        logic out_free;
    } kmp_status_t;

endpackage

`default_nettype wire

>>> design/kmp_ram.sv
// kmp_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/kmp_ctrl.sv
// kmp_ctrl: sequencer for the KMP matcher; walks each beat through
// decide, failure-chain steps, update and result hand-off. Uses kmp_pkg.
`default_nettype none

module kmp_ctrl
    import kmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire kmp_status_t status,
    output kmp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_POST   = 3'd4;
    localparam logic [2:0] ST_MFIX   = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.mode == KMP_MODE_PATTERN)
                begin
                    if (status.full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = ST_FIN;
                    end
                    else if (status.len_zero)
                    begin
                        cmd.pat_first = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        cmd.pat_start = 1'b1;
                        state_next    = ST_RD;
                    end
                end
                else
                begin
                    if (status.len_zero)
                    begin
                        cmd.txt_empty = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        cmd.txt_start = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = status.step_more ? ST_RD : ST_POST;
            end
            ST_POST:
            begin
                if (status.mode == KMP_MODE_PATTERN)
                begin
                    cmd.pat_post = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.txt_post     = 1'b1;
                    cmd.fail_sel_len = 1'b1;
                    state_next       = status.is_match ? ST_MFIX : ST_FIN;
                end
            end
            ST_MFIX:
            begin
                cmd.mc_fix = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/kmp_datapath.sv
// kmp_datapath: pattern store, failure table, match state, text position
// and output register of the KMP matcher. Uses kmp_pkg and kmp_ram.
`default_nettype none

module kmp_datapath
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN,
    parameter int POS_BITS    = KMP_POS_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire kmp_in_t  in_data,
    input  wire kmp_cmd_t cmd,
    output kmp_status_t   status,
    output logic          out_valid,
    input  wire logic     out_ready,
    output kmp_out_t      out_data
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = $clog2(MAX_PATTERN);

    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    bpl_reg;
    logic [LEN_W-1:0]    mc_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [LEN_W-1:0]    j_reg;
    logic [LEN_W-1:0]    j_next;
    logic                mode_reg;
    logic [7:0]          char_reg;
    logic                res_match_reg;
    logic [KMP_START_W-1:0] res_start_reg;
    logic                res_ovf_reg;
    logic                out_valid_reg;
    kmp_out_t            out_data_reg;

    logic [7:0]          store_q;
    logic [ADDR_W-1:0]   fail_q;
    logic [ADDR_W-1:0]   fail_raddr;
    logic [ADDR_W-1:0]   fail_wdata;
    logic [LEN_W-1:0]    len_m1;
    logic [LEN_W-1:0]    j_m1;
    logic [POS_BITS-1:0] start_pos;
    logic [63:0]         start_wide;
    logic                store_hit;

    assign len_m1    = len_reg - LEN_W'(1);
    assign j_m1      = j_reg - LEN_W'(1);
    assign store_hit = (store_q == char_reg);

    assign fail_raddr = cmd.fail_sel_len ? len_m1[ADDR_W-1:0] : j_m1[ADDR_W-1:0];
    assign fail_wdata = cmd.pat_first ? '0 : j_reg[ADDR_W-1:0];

    // occurrence started len-1 bytes before the current one
    assign start_pos  = pos_reg - POS_BITS'(len_reg) + POS_BITS'(1);
    assign start_wide = 64'(start_pos);

    kmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.pat_first | cmd.pat_start),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (char_reg),
        .raddr (j_reg[ADDR_W-1:0]),
        .rdata (store_q)
    );

    kmp_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_PATTERN)
    ) u_fail (
        .clk   (clk),
        .we    (cmd.pat_first | cmd.pat_post),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_q)
    );

    always_comb
    begin
        j_next = j_reg;
        if (cmd.pat_start)
        begin
            j_next = bpl_reg;
        end
        else if (cmd.txt_start)
        begin
            j_next = (mc_reg >= len_reg) ? '0 : mc_reg;
        end
        else if (cmd.step)
        begin
            if (status.step_more)
            begin
                j_next = LEN_W'(fail_q);
            end
            else if (store_hit)
            begin
                j_next = j_reg + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        status.mode      = mode_reg;
        status.full      = (len_reg >= LEN_W'(MAX_PATTERN));
        status.len_zero  = (len_reg == '0);
        status.step_more = (j_reg != '0) && !store_hit;
        status.is_match  = (j_reg >= len_reg);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // match state and pattern bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            bpl_reg       <= '0;
            mc_reg        <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_data.first)
            begin
                mc_reg <= '0;
                if (in_data.mode == KMP_MODE_PATTERN)
                begin
                    len_reg <= '0;
                    bpl_reg <= '0;
                end
                else
                begin
                    pos_reg <= '0;
                end
            end
            if (cmd.pat_first)
            begin
                bpl_reg <= '0;
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.pat_post)
            begin
                bpl_reg <= j_reg;
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.txt_empty)
            begin
                pos_reg <= pos_reg + POS_BITS'(1);
            end
            if (cmd.txt_post)
            begin
                mc_reg  <= j_reg;
                pos_reg <= pos_reg + POS_BITS'(1);
            end
            if (cmd.mc_fix)
            begin
                mc_reg <= LEN_W'(fail_q);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        if (cmd.load)
        begin
            mode_reg      <= in_data.mode;
            char_reg      <= in_data.char_in;
            res_match_reg <= 1'b0;
            res_start_reg <= '0;
            res_ovf_reg   <= 1'b0;
        end
        if (cmd.set_ovf)
        begin
            res_ovf_reg <= 1'b1;
        end
        if (cmd.txt_post && status.is_match)
        begin
            res_match_reg <= 1'b1;
            res_start_reg <= start_wide[KMP_START_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.match       <= res_match_reg;
            out_data_reg.match_start <= res_start_reg;
            out_data_reg.overflow    <= res_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_step_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (j_reg < len_reg))
        else $error("failure-chain step beyond pattern length");

    a_mc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        mc_reg <= len_reg)
        else $error("matched count exceeds pattern length");

    a_bpl_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) || (bpl_reg < len_reg))
        else $error("build prefix length not below pattern length");

    a_match_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.txt_post && status.is_match) |=> cmd.mc_fix)
        else $error("match without failure reload of matched count");

endmodule

`default_nettype wire

>>> design/kmp_string_matcher.sv
// kmp_string_matcher: top level of the streaming KMP matcher.
// Depends on kmp_pkg, kmp_ctrl, kmp_datapath (which uses kmp_ram).
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   in_data  (mode, char_in, first)
//   out      out  out_valid / out_ready out_data (match, match_start, overflow)
//
// One beat at a time; an empty or full pattern or a first pattern byte skips
// the compare steps, else there are k >= 1 (the first compare plus one per
// failure link followed), each one registered read of the pattern store and
// failure table, then the update and, on a match, a matched-count reload.
// Reset is asynchronous and clears the pattern length and match state; the
// stores need no clearing. A new beat is taken while the previous result
// waits; a stalled output holds the sequencer in its final state.
`default_nettype none

module kmp_string_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN,
    parameter int POS_BITS    = KMP_POS_BITS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire kmp_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output kmp_out_t     out_data
);

    kmp_cmd_t    cmd;
    kmp_status_t status;

    kmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kmp_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_BITS    (POS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
